[rtl/sabc_pkg.sv]
package sabc_pkg;

   localparam int NUM_ROUNDS_DEFAULT = 32;
   localparam int BLOCK_WIDTH = 64;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CONST_WRAP = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_LOW = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_HIGH = 1'd1;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef logic [15:0][3:0] map_type;

   // byte i of the result takes byte map[i] of the source
   localparam map_type FWD_MAP = {
      4'd3, 4'd10, 4'd8, 4'd4, 4'd0, 4'd13, 4'd6, 4'd11,
      4'd15, 4'd5, 4'd1, 4'd2, 4'd9, 4'd14, 4'd12, 4'd7
   };
   localparam map_type INV_MAP = {
      4'd7, 4'd2, 4'd10, 4'd1, 4'd8, 4'd14, 4'd3, 4'd13,
      4'd0, 4'd9, 4'd6, 4'd12, 4'd15, 4'd4, 4'd5, 4'd11
   };

   typedef struct packed {
      logic                   valid;
      logic                   opcode;
      logic [BLOCK_WIDTH-1:0] block_low;
      logic [BLOCK_WIDTH-1:0] block_high;
   } stage_type;

   typedef struct packed {
      logic [BLOCK_WIDTH-1:0] key_low;
      logic [BLOCK_WIDTH-1:0] key_high;
   } key_type;

   function automatic logic [2*BLOCK_WIDTH-1:0] permute(
      input logic [2*BLOCK_WIDTH-1:0] data,
      input map_type                  map
   );
      logic [2*BLOCK_WIDTH-1:0] result;
      result = '0;
      for (int i = 0; i < 16; i++) begin
         result[8*i +: 8] = data[8*map[i] +: 8];
      end
      return result;
   endfunction

endpackage

[rtl/sabc_if.sv]
interface sabc_req_if;
   logic                             valid;
   logic                             ready;
   logic                             opcode;
   logic [sabc_pkg::BLOCK_WIDTH-1:0] block_low;
   logic [sabc_pkg::BLOCK_WIDTH-1:0] block_high;

   modport source (output valid, output opcode, output block_low, output block_high,
                   input ready);
   modport sink (input valid, input opcode, input block_low, input block_high,
                 output ready);
endinterface

interface sabc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [sabc_pkg::BLOCK_WIDTH-1:0] result_low;
   logic [sabc_pkg::BLOCK_WIDTH-1:0] result_high;

   modport source (output valid, output result_low, output result_high, input ready);
   modport sink (input valid, input result_low, input result_high, output ready);
endinterface

interface sabc_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [sabc_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [sabc_pkg::BLOCK_WIDTH-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/sabc_cell.sv]
module sabc_cell #(
   parameter int STAGE = 0,
   parameter int NUM_ROUNDS = sabc_pkg::NUM_ROUNDS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  sabc_pkg::stage_type up_stage,
   output logic                up_ready,
   output sabc_pkg::stage_type down_stage,
   input  logic                down_ready,
   input  sabc_pkg::key_type   key
);

   localparam int BW = sabc_pkg::BLOCK_WIDTH;
   localparam int ENC_SHIFT = STAGE % sabc_pkg::CONST_WRAP;
   localparam int DEC_SHIFT = (NUM_ROUNDS - 1 - STAGE) % sabc_pkg::CONST_WRAP;
   localparam logic [BW-1:0] ENC_CONST = BW'(1) << ENC_SHIFT;
   localparam logic [BW-1:0] DEC_CONST = BW'(1) << DEC_SHIFT;

   logic                valid_ff;
   logic                opcode_ff;
   logic [2*BW-1:0]     data_ff;
   logic [2*BW-1:0]     data_in;
   logic [2*BW-1:0]     enc_perm;
   logic [2*BW-1:0]     dec_perm;
   logic                advance;

   assign up_ready = !valid_ff || down_ready;
   assign advance  = up_ready;

   always_comb begin
      enc_perm = sabc_pkg::permute({up_stage.block_high ^ ENC_CONST,
                                    up_stage.block_low ^ ENC_CONST}, sabc_pkg::FWD_MAP);
      dec_perm = sabc_pkg::permute({up_stage.block_high - key.key_high,
                                    up_stage.block_low - key.key_low}, sabc_pkg::INV_MAP);
      if (up_stage.opcode == sabc_pkg::OP_DECRYPT) begin
         data_in = {dec_perm[2*BW-1:BW] ^ DEC_CONST, dec_perm[BW-1:0] ^ DEC_CONST};
      end else begin
         data_in = {enc_perm[2*BW-1:BW] + key.key_high, enc_perm[BW-1:0] + key.key_low};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && up_stage.valid) begin
         opcode_ff <= up_stage.opcode;
         data_ff   <= data_in;
      end
   end

   assign down_stage.valid      = valid_ff;
   assign down_stage.opcode     = opcode_ff;
   assign down_stage.block_low  = data_ff[BW-1:0];
   assign down_stage.block_high = data_ff[2*BW-1:BW];

endmodule

[rtl/shuffle_add_block_cipher_top.sv]
// channel   dir   handshake      payload
// req_chan  in    valid/ready    opcode, block_low, block_high
// rsp_chan  out   valid/ready    result_low, result_high
// csr_chan  in    valid/ready    index (0 key_low, 1 key_high), data
//
// one cell per round, NUM_ROUNDS cells in a row, each holding its item in a register;
// a new item is taken every cycle while the result side keeps up
// each cell holds its item until the next cell frees, so bubbles close up on a stall
// synchronous reset clears the cell valid bits and zeroes the key
// csr writes are always taken and registered into the key
module shuffle_add_block_cipher_top #(
   parameter int NUM_ROUNDS = sabc_pkg::NUM_ROUNDS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   sabc_req_if.sink   req_chan,
   sabc_rsp_if.source rsp_chan,
   sabc_csr_if.sink   csr_chan
);

   sabc_pkg::stage_type chain [NUM_ROUNDS+1];
   logic                ready_chain [NUM_ROUNDS+1];
   logic [NUM_ROUNDS-1:0] valid_vec;
   sabc_pkg::key_type   key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            sabc_pkg::CSR_KEY_LOW:  key_ff.key_low  <= csr_chan.data;
            sabc_pkg::CSR_KEY_HIGH: key_ff.key_high <= csr_chan.data;
            default: ;
         endcase
      end
   end

   assign csr_chan.ready = 1'b1;

   assign chain[0].valid      = req_chan.valid;
   assign chain[0].opcode     = req_chan.opcode;
   assign chain[0].block_low  = req_chan.block_low;
   assign chain[0].block_high = req_chan.block_high;
   assign req_chan.ready      = ready_chain[0];

   for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_cell
      sabc_cell #(
         .STAGE(i),
         .NUM_ROUNDS(NUM_ROUNDS)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .up_stage(chain[i]),
         .up_ready(ready_chain[i]),
         .down_stage(chain[i+1]),
         .down_ready(ready_chain[i+1]),
         .key(key_ff)
      );
      assign valid_vec[i] = chain[i+1].valid;
   end

   assign ready_chain[NUM_ROUNDS] = rsp_chan.ready;
   assign rsp_chan.valid          = chain[NUM_ROUNDS].valid;
   assign rsp_chan.result_low     = chain[NUM_ROUNDS].block_low;
   assign rsp_chan.result_high    = chain[NUM_ROUNDS].block_high;

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&valid_vec) && !rsp_chan.ready |-> !req_chan.ready)
      else $error("input taken while every cell is full and stalled");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> valid_vec[0])
      else $error("accepted item did not reach the first cell");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");

endmodule
